### rtl/mandelbrot_escape_pixel_defines.svh
// Assertion macros for the Mandelbrot escape-time pixel block.
`ifndef MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mep_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time pixel block.
`timescale 1ns / 1ps

package mep_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int Q_W         = 32;
  localparam int OFS_W       = 13;
  localparam int ZOOM_W      = 16;
  localparam int ITER_W      = 16;
  localparam int PIX_W       = 10;
  localparam int SHADE_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_W       = 15;
  localparam int MAG_W       = NUM_W - 1;
  localparam int DVD_W       = MAG_W + FRAC_BITS;
  localparam int SAT_W       = DVD_W + 1;
  localparam int PROD_W      = 2 * Q_W;
  localparam int SQ_W        = PROD_W - 1;
  localparam int UPD_W       = PROD_W - FRAC_BITS + 2;
  localparam int COL_SHIFT   = 150;
  localparam int QUEUE_DEPTH = 2;

  localparam int IMG_WIDTH_DEF  = 1024;
  localparam int IMG_HEIGHT_DEF = 1024;

  localparam logic [SHADE_W-1:0] SHADE_OUT = 8'd255;
  localparam logic [SHADE_W-1:0] SHADE_IN  = 8'd0;

  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

  localparam logic [OFS_W-1:0]  PAN_X_RST    = OFS_W'(-10);
  localparam logic [OFS_W-1:0]  PAN_Y_RST    = OFS_W'(0);
  localparam logic [ZOOM_W-1:0] ZOOM_RST     = ZOOM_W'(350);
  localparam logic [ITER_W-1:0] ITER_LIM_RST = ITER_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAN_X    = 2'd0,
    REG_PAN_Y    = 2'd1,
    REG_ZOOM     = 2'd2,
    REG_ITER_LIM = 2'd3
  } mep_reg_e;

  typedef struct packed {
    logic signed [OFS_W-1:0] pan_x;
    logic signed [OFS_W-1:0] pan_y;
    logic [ZOOM_W-1:0]       zoom;
    logic [ITER_W-1:0]       iter_lim;
  } mep_cfg_t;

  typedef struct packed {
    logic signed [Q_W-1:0] cr;
    logic signed [Q_W-1:0] ci;
  } mep_point_t;

  // Clamp a wide signed value into Q4.28.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !v[SAT_W-1] && (|v[SAT_W-2:Q_W-1]);
    neg_ovf = v[SAT_W-1] && !(&v[SAT_W-2:Q_W-1]);
    if (pos_ovf) begin
      sat_q = {1'b0, {(Q_W-1){1'b1}}};
    end else if (neg_ovf) begin
      sat_q = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

endpackage

### rtl/mep_front.sv
// Front end: takes a pixel request, maps it to c with two bit-serial dividers.
`timescale 1ns / 1ps

module mep_front #(
  parameter int IMG_WIDTH  = mep_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = mep_pkg::IMG_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mep_pkg::mep_cfg_t          cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [mep_pkg::PIX_W-1:0]  col_i,
  input  logic [mep_pkg::PIX_W-1:0]  row_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output mep_pkg::mep_point_t        push_data_o
);

  localparam int NW    = mep_pkg::NUM_W;
  localparam int MW    = mep_pkg::MAG_W;
  localparam int DW    = mep_pkg::DVD_W;
  localparam int SW    = mep_pkg::SAT_W;
  localparam int ZW    = mep_pkg::ZOOM_W;
  localparam int CNT_W = $clog2(DW);
  localparam logic signed [NW-1:0] XBias = NW'(mep_pkg::COL_SHIFT + IMG_WIDTH / 2);
  localparam logic signed [NW-1:0] YBias = NW'(IMG_HEIGHT / 2);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [ZW-1:0]      div_q;
  logic [ZW-1:0]      rem_q [2];
  logic [ZW-1:0]      rem_d [2];
  logic [DW-1:0]      dvd_q [2];
  logic [DW-1:0]      dvd_d [2];
  logic               neg_q [2];

  logic signed [NW-1:0] num [2];
  logic [MW-1:0]        mag [2];
  logic                 in_fire;
  logic [ZW:0]          trial [2];
  logic                 ge [2];
  logic signed [SW-1:0] qval [2];

  assign in_ready_o   = (state_q == F_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign push_valid_o = (state_q == F_PUSH);

  always_comb begin
    num[0] = NW'(cfg_i.pan_x) + NW'($signed({1'b0, col_i})) - XBias;
    num[1] = YBias - NW'(cfg_i.pan_y) - NW'($signed({1'b0, row_i}));
    for (int l = 0; l < 2; l++) begin
      mag[l] = num[l][NW-1] ? MW'(-num[l]) : MW'(num[l]);
      // Restoring step: remainder stays below the divisor, so 16 bits hold it.
      trial[l] = {rem_q[l], dvd_q[l][DW-1]};
      ge[l]    = (trial[l] >= {1'b0, div_q});
      rem_d[l] = ge[l] ? ZW'(trial[l] - {1'b0, div_q}) : trial[l][ZW-1:0];
      dvd_d[l] = {dvd_q[l][DW-2:0], ge[l]};
      qval[l]  = neg_q[l] ? -$signed({1'b0, dvd_q[l]}) : $signed({1'b0, dvd_q[l]});
    end
  end

  assign push_data_o.cr = mep_pkg::sat_q(qval[0]);
  assign push_data_o.ci = mep_pkg::sat_q(qval[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_fire) begin
            state_q <= F_DIV;
            cnt_q   <= CNT_W'(DW - 1);
          end
        end
        F_DIV: begin
          if (cnt_q == '0) begin
            state_q <= F_PUSH;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        F_PUSH: begin
          if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      // Zoom of zero divides by one.
      div_q <= (cfg_i.zoom == '0) ? ZW'(1) : cfg_i.zoom;
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= '0;
        dvd_q[l] <= {mag[l], {mep_pkg::FRAC_BITS{1'b0}}};
        neg_q[l] <= num[l][NW-1];
      end
    end else if (state_q == F_DIV) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_d[l];
        dvd_q[l] <= dvd_d[l];
      end
    end
  end

endmodule

### rtl/mep_queue.sv
// Short register queue of mapped points between the front and back ends.
`timescale 1ns / 1ps

module mep_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  mep_pkg::mep_point_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output mep_pkg::mep_point_t pop_data_o
);

  localparam int Depth = mep_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(Depth);

  mep_pkg::mep_point_t mem_q [Depth];
  logic [AW-1:0]       wr_ptr_q;
  logic [AW-1:0]       rd_ptr_q;
  logic [AW:0]         count_q;
  logic                push_fire;
  logic                pop_fire;

  assign push_ready_o = (count_q != (AW+1)'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_fire) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_fire && !pop_fire) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (pop_fire && !push_fire) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/mep_back.sv
// Back end: iterates z = z*z + c on one point and registers the shade.
`timescale 1ns / 1ps

module mep_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mep_pkg::ITER_W-1:0]   iter_lim_i,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  mep_pkg::mep_point_t          pop_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mep_pkg::SHADE_W-1:0]  shade_o
);

  localparam int QW = mep_pkg::Q_W;
  localparam int PW = mep_pkg::PROD_W;
  localparam int SQ = mep_pkg::SQ_W;
  localparam int UW = mep_pkg::UPD_W;
  localparam int SW = mep_pkg::SAT_W;
  localparam int IW = mep_pkg::ITER_W;
  localparam int FB = mep_pkg::FRAC_BITS;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SUM,
    B_UPD,
    B_FIN
  } state_e;

  state_e                        state_q;
  logic [IW-1:0]                 n_q;
  logic                          out_valid_q;
  logic [mep_pkg::SHADE_W-1:0]   shade_q;
  logic [mep_pkg::SHADE_W-1:0]   res_q;

  logic signed [QW-1:0] cr_q;
  logic signed [QW-1:0] ci_q;
  logic signed [QW-1:0] zr_q;
  logic signed [QW-1:0] zi_q;
  logic [SQ-1:0]        sr_q;
  logic [SQ-1:0]        si_q;
  logic signed [PW-1:0] cross_q;
  logic signed [PW-1:0] diff_q;

  logic signed [PW-1:0] p_rr;
  logic signed [PW-1:0] p_ii;
  logic signed [PW-1:0] p_ri;
  logic [PW-1:0]        mag;
  logic                 esc;
  logic signed [PW-1:0] diff;
  logic                 corr_r;
  logic                 corr_i;
  logic signed [UW-1:0] sum_r;
  logic signed [UW-1:0] sum_i;
  logic signed [QW-1:0] zr_nxt;
  logic signed [QW-1:0] zi_nxt;
  logic                 pop_fire;
  logic                 can_load;
  logic                 fin_load;
  logic                 last_iter;

  assign pop_ready_o = (state_q == B_IDLE);
  assign pop_fire    = pop_valid_i && pop_ready_o;
  assign can_load    = !out_valid_q || out_ready_i;
  assign fin_load    = (state_q == B_FIN) && can_load;
  assign out_valid_o = out_valid_q;
  assign shade_o     = shade_q;
  assign last_iter   = (IW'(n_q + IW'(1)) == iter_lim_i);

  always_comb begin
    p_rr = PW'(zr_q) * PW'(zr_q);
    p_ii = PW'(zi_q) * PW'(zi_q);
    p_ri = PW'(zr_q) * PW'(zi_q);
    mag  = {1'b0, sr_q} + {1'b0, si_q};
    esc  = (mag > mep_pkg::ESC_LIMIT);
    diff = $signed({1'b0, sr_q}) - $signed({1'b0, si_q});
    // Truncate toward zero: bump negative values that lose fraction bits.
    corr_r = diff_q[PW-1] && (|diff_q[FB-1:0]);
    corr_i = cross_q[PW-1] && (|cross_q[FB-2:0]);
    sum_r  = UW'($signed(diff_q[PW-1:FB])) + UW'(cr_q) + UW'({1'b0, corr_r});
    sum_i  = UW'($signed(cross_q[PW-1:FB-1])) + UW'(ci_q) + UW'({1'b0, corr_i});
    zr_nxt = mep_pkg::sat_q(SW'(sum_r));
    zi_nxt = mep_pkg::sat_q(SW'(sum_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      n_q         <= '0;
      res_q       <= mep_pkg::SHADE_IN;
      out_valid_q <= 1'b0;
      shade_q     <= mep_pkg::SHADE_IN;
    end else begin
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_fire) begin
            n_q <= '0;
            // Limit of zero: no iteration, point counts as inside.
            if (iter_lim_i == '0) begin
              res_q   <= mep_pkg::SHADE_IN;
              state_q <= B_FIN;
            end else begin
              state_q <= B_MUL;
            end
          end
        end
        B_MUL: state_q <= B_SUM;
        B_SUM: begin
          if (esc) begin
            res_q   <= mep_pkg::SHADE_OUT;
            state_q <= B_FIN;
          end else begin
            state_q <= B_UPD;
          end
        end
        B_UPD: begin
          n_q <= n_q + IW'(1);
          if (last_iter) begin
            res_q   <= mep_pkg::SHADE_IN;
            state_q <= B_FIN;
          end else begin
            state_q <= B_MUL;
          end
        end
        B_FIN: begin
          if (can_load) begin
            shade_q <= res_q;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      cr_q <= pop_data_i.cr;
      ci_q <= pop_data_i.ci;
      zr_q <= '0;
      zi_q <= '0;
    end else begin
      case (state_q)
        B_MUL: begin
          sr_q    <= p_rr[SQ-1:0];
          si_q    <= p_ii[SQ-1:0];
          cross_q <= p_ri;
        end
        B_SUM: diff_q <= diff;
        B_UPD: begin
          zr_q <= zr_nxt;
          zi_q <= zi_nxt;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/mandelbrot_escape_pixel.sv
// Top level of the Mandelbrot escape-time pixel block: config registers and wiring.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   in      | input     | in_valid_i / in_ready_o   | col_i[9:0], row_i[9:0]
//   out     | output    | out_valid_o / out_ready_i | shade_o[7:0]
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i[1:0], cfg_data_i[15:0]
//
// The front end takes a new request only once the last one has gone into the
// queue (two 42-step serial dividers). The back end runs each iteration through
// its multiply, magnitude/difference and update states, taking the point in idle
// and handing off the shade in its finish state; this loop sets the sustained
// rate. A two-entry queue lets the front map later pixels while the back iterates;
// a finished shade waits in the output register without holding up the queue.
// Reset clears control state and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
`include "mandelbrot_escape_pixel_defines.svh"

module mandelbrot_escape_pixel #(
  parameter int IMG_WIDTH  = mep_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = mep_pkg::IMG_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mep_pkg::PIX_W-1:0]       col_i,
  input  logic [mep_pkg::PIX_W-1:0]       row_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mep_pkg::SHADE_W-1:0]     shade_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mep_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  mep_pkg::mep_cfg_t   cfg_q;
  mep_pkg::mep_point_t push_data;
  mep_pkg::mep_point_t pop_data;
  logic                push_valid;
  logic                push_ready;
  logic                pop_valid;
  logic                pop_ready;
  logic                in_fire;
  logic                pop_fire;
  logic                shade_ok;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign pop_fire    = pop_valid && pop_ready;
  assign shade_ok    = (shade_o == mep_pkg::SHADE_OUT) || (shade_o == mep_pkg::SHADE_IN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pan_x    <= mep_pkg::PAN_X_RST;
      cfg_q.pan_y    <= mep_pkg::PAN_Y_RST;
      cfg_q.zoom     <= mep_pkg::ZOOM_RST;
      cfg_q.iter_lim <= mep_pkg::ITER_LIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mep_pkg::mep_reg_e'(cfg_index_i))
        mep_pkg::REG_PAN_X:    cfg_q.pan_x    <= cfg_data_i[mep_pkg::OFS_W-1:0];
        mep_pkg::REG_PAN_Y:    cfg_q.pan_y    <= cfg_data_i[mep_pkg::OFS_W-1:0];
        mep_pkg::REG_ZOOM:     cfg_q.zoom     <= cfg_data_i[mep_pkg::ZOOM_W-1:0];
        mep_pkg::REG_ITER_LIM: cfg_q.iter_lim <= cfg_data_i[mep_pkg::ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mep_front #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .col_i        (col_i),
    .row_i        (row_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mep_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iter_lim_i  (cfg_q.iter_lim),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .shade_o     (shade_o)
  );

  `MEP_ASSERT_NOW(a_shade_code, out_valid_o, shade_ok, "shade is neither inside nor escaped")
  `MEP_ASSERT_NEXT(a_front_busy, in_fire, !in_ready_o, "front took a request while mapping")
  `MEP_ASSERT_NEXT(a_back_busy, pop_fire, !pop_ready, "back took a point while iterating")

endmodule
